[sv/ppq_pkg.sv]
// Package for the promotable priority queue: fixed field widths, request and
// status codes, and the per-cell command struct.
// No dependencies.
`default_nettype none

package ppq_pkg;

  localparam int REQ_W      = 3;
  localparam int VAL_IO_W   = 32;
  localparam int ID_W       = 4;
  localparam int STATUS_W   = 2;
  localparam int PRI_IO_W   = 16;
  localparam int SEQ_W      = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD      = 3'd0,
    REQ_PROMOTE  = 3'd1,
    REQ_GET_MAX  = 3'd2,
    REQ_POP_MAX  = 3'd3,
    REQ_IS_VALID = 3'd4,
    REQ_GET      = 3'd5
  } req_code_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_code_t;

  // Update strobes for one cell; at most one is set per cycle.
  typedef struct packed {
    logic add;
    logic promote;
    logic clear;
  } ppq_cell_cmd_t;

endpackage

`default_nettype wire

[sv/promotable_priority_queue_unit.sv]
// One request at a time: a new request is taken only once the previous one has
// committed its result, after the max-search and free-slot chains have rippled
// through the CAPACITY registered cells.
// A new request may be taken while the previous result is still stalled.
// Reset (rst_n low, synchronous): all slots free, add sequence zero, idle.
// Depends on ppq_pkg and ppq_cell.
`default_nettype none

module promotable_priority_queue_unit #(
  parameter int CAPACITY       = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ppq_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ppq_pkg::VAL_IO_W-1:0] in_value_in,
  input  logic [ppq_pkg::ID_W-1:0]     in_item_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppq_pkg::STATUS_W-1:0] out_status,
  output logic [ppq_pkg::ID_W-1:0]     out_id_out,
  output logic [ppq_pkg::VAL_IO_W-1:0] out_value_out,
  output logic [ppq_pkg::PRI_IO_W-1:0] out_priority_out,
  output logic                         out_id_valid
);
  import ppq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_EXEC
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REQ_W-1:0]  req_r;
  logic [VAL_IO_W-1:0] val_r;
  logic [ID_W-1:0]   id_r;
  logic [SEQ_W-1:0]  add_seq_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [VAL_IO_W-1:0] out_value_r;
  logic [PRI_IO_W-1:0] out_pri_r;
  logic                out_id_valid_r;

  // chain links: entry 0 feeds cell 0, entry CAPACITY is the tail
  logic                      bfound_c [CAPACITY+1];
  logic [IDX_W-1:0]          bidx_c   [CAPACITY+1];
  logic [PRIORITY_WIDTH-1:0] bpri_c   [CAPACITY+1];
  logic [SEQ_W-1:0]          bseq_c   [CAPACITY+1];
  logic                      ffound_c [CAPACITY+1];
  logic [IDX_W-1:0]          fidx_c   [CAPACITY+1];

  logic [CAPACITY-1:0]       used_v;
  logic [VALUE_WIDTH-1:0]    value_a [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] pri_a   [CAPACITY];

  ppq_cell_cmd_t       cmd_a [CAPACITY];
  logic [CAPACITY-1:0] add_v;
  logic [CAPACITY-1:0] clear_v;
  logic [CAPACITY-1:0] promote_v;

  logic [VALUE_WIDTH-1:0] add_value;
  logic [IDX_W-1:0]       id_idx;
  logic                   id_known;
  logic                   fire;
  logic                   accept;

  logic                do_add, do_promote, do_pop;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic [VAL_IO_W-1:0] res_value;
  logic [PRI_IO_W-1:0] res_pri;
  logic                res_id_valid;

  assign bfound_c[0] = 1'b0;
  assign bidx_c[0]   = '0;
  assign bpri_c[0]   = '0;
  assign bseq_c[0]   = '0;
  assign ffound_c[0] = 1'b0;
  assign fidx_c[0]   = '0;

  assign add_value = VALUE_WIDTH'(val_r);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ppq_cell #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH),
      .IDX_W          (IDX_W),
      .INDEX          (g)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd_a[g]),
      .add_value      (add_value),
      .add_seq        (add_seq_r),
      .best_found_in  (bfound_c[g]),
      .best_idx_in    (bidx_c[g]),
      .best_pri_in    (bpri_c[g]),
      .best_seq_in    (bseq_c[g]),
      .best_found_out (bfound_c[g+1]),
      .best_idx_out   (bidx_c[g+1]),
      .best_pri_out   (bpri_c[g+1]),
      .best_seq_out   (bseq_c[g+1]),
      .free_found_in  (ffound_c[g]),
      .free_idx_in    (fidx_c[g]),
      .free_found_out (ffound_c[g+1]),
      .free_idx_out   (fidx_c[g+1]),
      .used           (used_v[g]),
      .value          (value_a[g]),
      .prio           (pri_a[g])
    );
  end

  // Request handshake: take a new request only when idle.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // Result leaves EXEC once the output register is free or being emptied.
  assign fire     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  // Slot lookup by id; ids at or beyond CAPACITY are unknown.
  assign id_idx   = IDX_W'(id_r);
  assign id_known = (int'(id_r) < CAPACITY) && used_v[id_idx];

  // Result and update decision, from the settled chain tails.
  always_comb begin
    do_add       = 1'b0;
    do_promote   = 1'b0;
    do_pop       = 1'b0;
    res_status   = STAT_OK;
    res_id       = '0;
    res_value    = '0;
    res_pri      = '0;
    res_id_valid = 1'b0;
    unique case (req_r)
      REQ_ADD: begin
        if (!ffound_c[CAPACITY] || (add_seq_r == '1)) begin
          res_status = STAT_FULL;
        end else begin
          do_add = 1'b1;
          res_id = ID_W'(fidx_c[CAPACITY]);
        end
      end
      REQ_PROMOTE: begin
        if (!id_known) begin
          res_status = STAT_UNKNOWN;
        end else begin
          do_promote = 1'b1;
        end
      end
      REQ_GET_MAX, REQ_POP_MAX: begin
        if (!bfound_c[CAPACITY]) begin
          res_status = STAT_EMPTY;
        end else begin
          res_id    = ID_W'(bidx_c[CAPACITY]);
          res_value = VAL_IO_W'(value_a[bidx_c[CAPACITY]]);
          res_pri   = PRI_IO_W'(pri_a[bidx_c[CAPACITY]]);
          do_pop    = (req_r == REQ_POP_MAX);
        end
      end
      REQ_IS_VALID: begin
        res_id_valid = id_known;
      end
      REQ_GET: begin
        if (!id_known) begin
          res_status = STAT_UNKNOWN;
        end else begin
          res_value    = VAL_IO_W'(value_a[id_idx]);
          res_id_valid = 1'b1;
        end
      end
      default: begin
        // undefined request: all-zero result, no update
      end
    endcase
  end

  // Per-cell strobes, only on the cycle the result is committed.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      add_v[i]     = fire && do_add && (fidx_c[CAPACITY] == IDX_W'(i));
      promote_v[i] = fire && do_promote && (id_idx == IDX_W'(i));
      clear_v[i]   = fire && do_pop && (bidx_c[CAPACITY] == IDX_W'(i));
      cmd_a[i].add     = add_v[i];
      cmd_a[i].promote = promote_v[i];
      cmd_a[i].clear   = clear_v[i];
    end
  end

  // Sequencer, request capture and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      add_seq_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a committed result refills the register, else a taken one empties it
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            // wait for the chains to reflect the last update through every registered cell
            state_r <= ST_SETTLE;
            cnt_r   <= CNT_W'(CAPACITY - 1);
          end
        end
        ST_SETTLE: begin
          if (cnt_r == '0) begin
            state_r <= ST_EXEC;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state_r <= ST_IDLE;
            if (do_add) begin
              add_seq_r <= add_seq_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (accept) begin
      req_r <= in_req_type;
      val_r <= in_value_in;
      id_r  <= in_item_id;
    end
    if (fire) begin
      out_status_r   <= res_status;
      out_id_r       <= res_id;
      out_value_r    <= res_value;
      out_pri_r      <= res_pri;
      out_id_valid_r <= res_id_valid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_id_out       = out_id_r;
  assign out_value_out    = out_value_r;
  assign out_priority_out = out_pri_r;
  assign out_id_valid     = out_id_valid_r;

  // At most one slot is filled and at most one freed per request.
  a_add_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(add_v))
    else $error("more than one slot filled at once");

  a_clear_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(clear_v))
    else $error("more than one slot freed at once");

  // A fill only targets a free slot.
  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    (|add_v) |-> ((add_v & used_v) == '0))
    else $error("add targets an occupied slot");

  // A freed slot was occupied and is the max entry.
  a_pop_used: assert property (@(posedge clk) disable iff (!rst_n)
    (|clear_v) |-> (bfound_c[CAPACITY] && ((clear_v & ~used_v) == '0)))
    else $error("pop frees an empty slot");

endmodule

`default_nettype wire

[sv/ppq_cell.sv]
// One slot of the queue plus its stage of the max-search and free-slot chains.
// Depends on ppq_pkg.
`default_nettype none

module ppq_cell #(
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16,
  parameter int IDX_W          = 4,
  parameter int INDEX          = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ppq_pkg::ppq_cell_cmd_t    cmd,
  input  logic [VALUE_WIDTH-1:0]    add_value,
  input  logic [ppq_pkg::SEQ_W-1:0] add_seq,
  // max-search chain
  input  logic                      best_found_in,
  input  logic [IDX_W-1:0]          best_idx_in,
  input  logic [PRIORITY_WIDTH-1:0] best_pri_in,
  input  logic [ppq_pkg::SEQ_W-1:0] best_seq_in,
  output logic                      best_found_out,
  output logic [IDX_W-1:0]          best_idx_out,
  output logic [PRIORITY_WIDTH-1:0] best_pri_out,
  output logic [ppq_pkg::SEQ_W-1:0] best_seq_out,
  // lowest-free chain
  input  logic                      free_found_in,
  input  logic [IDX_W-1:0]          free_idx_in,
  output logic                      free_found_out,
  output logic [IDX_W-1:0]          free_idx_out,
  // slot contents
  output logic                      used,
  output logic [VALUE_WIDTH-1:0]    value,
  output logic [PRIORITY_WIDTH-1:0] prio
);
  import ppq_pkg::*;

  logic                      used_r;
  logic [VALUE_WIDTH-1:0]    value_r;
  logic [PRIORITY_WIDTH-1:0] pri_r;
  logic [SEQ_W-1:0]          seq_r;

  logic                      bfound_r;
  logic [IDX_W-1:0]          bidx_r;
  logic [PRIORITY_WIDTH-1:0] bpri_r;
  logic [SEQ_W-1:0]          bseq_r;
  logic                      ffound_r;
  logic [IDX_W-1:0]          fidx_r;

  logic take_self;
  logic free_self;

  assign take_self = used_r && (!best_found_in || (pri_r > best_pri_in) ||
                     ((pri_r == best_pri_in) && (seq_r > best_seq_in)));
  assign free_self = !free_found_in && !used_r;

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (cmd.add) begin
      used_r <= 1'b1;
    end else if (cmd.clear) begin
      used_r <= 1'b0;
    end
    if (cmd.add) begin
      value_r <= add_value;
      pri_r   <= '0;
      seq_r   <= add_seq;
    end else if (cmd.promote && (pri_r != '1)) begin
      pri_r <= pri_r + 1'b1;
    end
  end

  // chain stages, running every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bfound_r <= 1'b0;
      ffound_r <= 1'b0;
    end else begin
      bfound_r <= best_found_in || used_r;
      ffound_r <= free_found_in || !used_r;
    end
    if (take_self) begin
      bidx_r <= IDX_W'(INDEX);
      bpri_r <= pri_r;
      bseq_r <= seq_r;
    end else begin
      bidx_r <= best_idx_in;
      bpri_r <= best_pri_in;
      bseq_r <= best_seq_in;
    end
    fidx_r <= free_self ? IDX_W'(INDEX) : free_idx_in;
  end

  assign best_found_out = bfound_r;
  assign best_idx_out   = bidx_r;
  assign best_pri_out   = bpri_r;
  assign best_seq_out   = bseq_r;
  assign free_found_out = ffound_r;
  assign free_idx_out   = fidx_r;
  assign used           = used_r;
  assign value          = value_r;
  assign prio           = pri_r;

endmodule

`default_nettype wire
